FILE: rtl/core/ring_pan_gain_calculator_top_assert.svh
// ----------------------------------------------------------------------------
// ring pan gain calculator assertion macros
// shared property forms for the checker
// ----------------------------------------------------------------------------
`ifndef RING_PAN_GAIN_CALCULATOR_TOP_ASSERT_SVH
`define RING_PAN_GAIN_CALCULATOR_TOP_ASSERT_SVH

// same-cycle implication, quiet during reset
`define RPG_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, quiet during reset
`define RPG_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: rtl/core/rpg_pkg.sv
// ----------------------------------------------------------------------------
// rpg_pkg
// shared types, constants and the speaker azimuth table
// ----------------------------------------------------------------------------
package rpg_pkg;

	localparam int MAX_CHANNELS_DEF = 16;
	localparam int RING_MAX_DEF     = 16;
	localparam int CH_ALL           = 16;
	localparam int AZ_W             = 13;
	localparam int GAIN_W           = 16;
	localparam int FULL_TURN        = 5760;
	localparam int UNITY            = 32768;
	localparam int QUO_BITS         = 16;
	localparam int STEP_BITS        = 2;
	localparam int DIV_STAGES       = QUO_BITS / STEP_BITS;
	localparam int MID_DEPTH        = 4;
	localparam int OUT_DEPTH        = 32;

	localparam logic CFG_COUNT  = 1'b0;
	localparam logic CFG_LAYOUT = 1'b1;

	typedef enum logic [1:0] {
		KIND_NONE = 2'd0,
		KIND_ONE  = 2'd1,
		KIND_PAIR = 2'd2
	} kind_t;

	typedef struct packed {
		kind_t           kind;
		logic [3:0]      first_ch;
		logic [3:0]      second_ch;
		logic [AZ_W-1:0] span;
		logic [AZ_W-1:0] into;
	} front_item_t;

	typedef struct packed {
		logic [3:0]        first_channel;
		logic [GAIN_W-1:0] first_gain;
		logic [3:0]        second_channel;
		logic [GAIN_W-1:0] second_gain;
		kind_t             pair_kind;
	} result_t;

	function automatic logic [AZ_W-1:0] az_lookup(input logic [3:0] code, input logic seven);
		logic [AZ_W-1:0] az;
		az = '0;
		case (code)
			4'd0: az = 13'd5280;
			4'd1: az = 13'd0;
			4'd2: az = 13'd480;
			4'd3: az = seven ? 13'd4320 : 13'd4000;
			4'd4: az = seven ? 13'd1440 : 13'd1760;
			4'd5: az = 13'd3600;
			4'd6: az = 13'd2160;
			4'd7: az = 13'd4800;
			4'd8: az = 13'd960;
			default: az = '0;
		endcase
		return az;
	endfunction

endpackage

FILE: rtl/core/rpg_fifo.sv
// ----------------------------------------------------------------------------
// rpg_fifo
// small register-based first-in first-out queue
// ----------------------------------------------------------------------------
module rpg_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] rdata,
	output logic             empty
);
	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PW-1:0]    wr_ptr_q;
	logic [PW-1:0]    rd_ptr_q;
	logic [CW-1:0]    cnt_q;
	logic             do_push;
	logic             do_pop;

	assign full    = (cnt_q == CW'(DEPTH));
	assign empty   = (cnt_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end
endmodule

FILE: rtl/core/rpg_front.sv
// ----------------------------------------------------------------------------
// rpg_front
// angle reduction and placement of the angle on the speaker ring
// ----------------------------------------------------------------------------
module rpg_front #(
	parameter int MAX_CHANNELS = rpg_pkg::MAX_CHANNELS_DEF,
	parameter int RING_MAX     = rpg_pkg::RING_MAX_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic [4:0]            channel_count,
	input  logic [63:0]           speaker_layout,
	input  logic                  in_valid,
	input  logic signed [15:0]    pan_angle,
	output logic                  out_valid,
	output rpg_pkg::front_item_t  out_item
);
	import rpg_pkg::*;

	logic [4:0]        n_lim;
	logic [3:0]        code_w [CH_ALL];
	logic              seven;
	logic [CH_ALL-1:0] cand;
	logic [CH_ALL-1:0] ring_nxt;
	logic [CH_ALL-1:0] lowm;
	logic [CH_ALL-1:0] ring_vld_q;
	logic [AZ_W-1:0]   az_q [CH_ALL];

	logic [17:0]       xs;
	logic              v_s1, v_s2, v_s3, v_s4, v_s5;
	logic [16:0]       x_s1, x_s2;
	logic [20:0]       qp;
	logic [3:0]        q_s2;
	logic [16:0]       qm;
	logic [16:0]       tdiff;
	logic [AZ_W-1:0]   t_s3, t_s4;

	logic [AZ_W:0]     mxb [CH_ALL];
	logic [AZ_W:0]     mxa [CH_ALL];
	logic [AZ_W:0]     mnb [CH_ALL];
	logic [AZ_W:0]     mna [CH_ALL];
	logic [CH_ALL-1:0] hit_m;
	logic [3:0]        hit_ch;
	logic [AZ_W-1:0]   a_s4, b_s4;
	logic              hit_s4, any_s4;
	logic [3:0]        hit_ch_s4;

	logic [3:0]        fch, sch;
	logic [AZ_W:0]     span_d, into_d;
	logic [AZ_W-1:0]   span_r, into_r;
	front_item_t       item;
	front_item_t       item_s5;

	// ring membership and azimuths from the layout
	assign n_lim = (channel_count > 5'(MAX_CHANNELS)) ? 5'(MAX_CHANNELS) : channel_count;

	always_comb begin
		seven    = 1'b0;
		cand     = '0;
		ring_nxt = '0;
		lowm     = '0;
		for (int c = 0; c < CH_ALL; c++) begin
			code_w[c] = speaker_layout[4*c +: 4];
			if (5'(c) < n_lim) begin
				if (code_w[c] >= 4'd5 && code_w[c] <= 4'd10) seven = 1'b1;
				if (code_w[c] <= 4'd8) cand[c] = 1'b1;
			end
		end
		for (int c = 0; c < CH_ALL; c++) begin
			lowm        = (CH_ALL'(1) << c) - CH_ALL'(1);
			ring_nxt[c] = cand[c] && ($countones(cand & lowm) < RING_MAX);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ring_vld_q <= '0;
		end else begin
			ring_vld_q <= ring_nxt;
		end
	end

	always_ff @(posedge clk) begin
		for (int c = 0; c < CH_ALL; c++) begin
			az_q[c] <= az_lookup(code_w[c], seven);
		end
	end

	// modulo 5760 by reciprocal multiply
	assign xs    = {{2{pan_angle[15]}}, pan_angle} + 18'd34560;
	assign qp    = x_s1[16:7] * 11'd1457;
	assign qm    = q_s2 * 17'(FULL_TURN);
	assign tdiff = x_s2 - qm;

	// neighbor search by max and min trees
	always_comb begin
		for (int i = 0; i < CH_ALL; i++) begin
			mxb[i]   = {ring_vld_q[i] && (az_q[i] < t_s3), az_q[i]};
			mxa[i]   = {ring_vld_q[i], az_q[i]};
			mnb[i]   = {!(ring_vld_q[i] && (az_q[i] > t_s3)), az_q[i]};
			mna[i]   = {!ring_vld_q[i], az_q[i]};
			hit_m[i] = ring_vld_q[i] && (az_q[i] == t_s3);
		end
		for (int lv = 0; lv < 4; lv++) begin
			for (int i = 0; i < CH_ALL; i++) begin
				if (((i & ((2 << lv) - 1)) == 0) && (i + (1 << lv) < CH_ALL)) begin
					if (mxb[i + (1 << lv)] > mxb[i]) mxb[i] = mxb[i + (1 << lv)];
					if (mxa[i + (1 << lv)] > mxa[i]) mxa[i] = mxa[i + (1 << lv)];
					if (mnb[i + (1 << lv)] < mnb[i]) mnb[i] = mnb[i + (1 << lv)];
					if (mna[i + (1 << lv)] < mna[i]) mna[i] = mna[i + (1 << lv)];
				end
			end
		end
		hit_ch = '0;
		for (int i = CH_ALL - 1; i >= 0; i--) begin
			if (hit_m[i]) hit_ch = 4'(i);
		end
	end

	// pair channels and distances
	always_comb begin
		fch = '0;
		sch = '0;
		for (int i = CH_ALL - 1; i >= 0; i--) begin
			if (ring_vld_q[i] && az_q[i] == a_s4) fch = 4'(i);
			if (ring_vld_q[i] && az_q[i] == b_s4) sch = 4'(i);
		end
		span_d = {1'b0, b_s4} + 14'(FULL_TURN) - {1'b0, a_s4};
		into_d = {1'b0, t_s4} + 14'(FULL_TURN) - {1'b0, a_s4};
		if (span_d >= 14'(FULL_TURN)) span_d = span_d - 14'(FULL_TURN);
		if (into_d >= 14'(FULL_TURN)) into_d = into_d - 14'(FULL_TURN);
		span_r = (span_d == '0) ? AZ_W'(FULL_TURN) : span_d[AZ_W-1:0];
		into_r = (into_d == '0) ? AZ_W'(FULL_TURN) : into_d[AZ_W-1:0];
		if (into_r > span_r) into_r = span_r;

		item.kind      = KIND_NONE;
		item.first_ch  = '0;
		item.second_ch = '0;
		item.span      = AZ_W'(1);
		item.into      = '0;
		if (!any_s4) begin
			item.kind = KIND_NONE;
		end else if (hit_s4) begin
			item.kind     = KIND_ONE;
			item.first_ch = hit_ch_s4;
		end else if (a_s4 == b_s4) begin
			item.kind     = KIND_ONE;
			item.first_ch = fch;
		end else begin
			item.kind      = KIND_PAIR;
			item.first_ch  = fch;
			item.second_ch = sch;
			item.span      = span_r;
			item.into      = into_r;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		x_s1      <= xs[16:0];
		x_s2      <= x_s1;
		q_s2      <= qp[19:16];
		t_s3      <= tdiff[AZ_W-1:0];
		t_s4      <= t_s3;
		a_s4      <= mxb[0][AZ_W] ? mxb[0][AZ_W-1:0] : mxa[0][AZ_W-1:0];
		b_s4      <= mnb[0][AZ_W] ? mna[0][AZ_W-1:0] : mnb[0][AZ_W-1:0];
		hit_s4    <= |hit_m;
		hit_ch_s4 <= hit_ch;
		any_s4    <= |ring_vld_q;
		item_s5   <= item;
	end

	assign out_valid = v_s5;
	assign out_item  = item_s5;
endmodule

FILE: rtl/core/rpg_back.sv
// ----------------------------------------------------------------------------
// rpg_back
// pipelined gain divider, two quotient bits per stage
// ----------------------------------------------------------------------------
module rpg_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	input  rpg_pkg::front_item_t in_item,
	output logic                 out_valid,
	output rpg_pkg::result_t     out_res
);
	import rpg_pkg::*;

	typedef struct packed {
		kind_t             kind;
		logic [3:0]        fch;
		logic [3:0]        sch;
		logic [AZ_W-1:0]   span;
		logic [AZ_W-1:0]   rem;
		logic [QUO_BITS-1:0] low;
		logic [QUO_BITS-1:0] quo;
	} div_t;

	function automatic div_t div_step(input div_t d);
		div_t        r;
		logic [AZ_W:0] r2;
		r = d;
		for (int j = 0; j < STEP_BITS; j++) begin
			r2    = {r.rem, r.low[QUO_BITS-1]};
			r.low = {r.low[QUO_BITS-2:0], 1'b0};
			if (r2 >= {1'b0, r.span}) begin
				r2    = r2 - {1'b0, r.span};
				r.quo = {r.quo[QUO_BITS-2:0], 1'b1};
			end else begin
				r.quo = {r.quo[QUO_BITS-2:0], 1'b0};
			end
			r.rem = r2[AZ_W-1:0];
		end
		return r;
	endfunction

	logic [27:0] num;
	div_t        d0;
	div_t        dv_s [DIV_STAGES+1];
	logic        vld_s [DIV_STAGES+1];
	div_t        fin;

	assign num = {in_item.into, 15'b0} + 28'(in_item.span >> 1);

	always_comb begin
		d0.kind = in_item.kind;
		d0.fch  = in_item.first_ch;
		d0.sch  = in_item.second_ch;
		d0.span = in_item.span;
		d0.rem  = AZ_W'(num[27:16]);
		d0.low  = num[15:0];
		d0.quo  = '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k <= DIV_STAGES; k++) vld_s[k] <= 1'b0;
		end else begin
			vld_s[0] <= in_valid;
			for (int k = 0; k < DIV_STAGES; k++) vld_s[k+1] <= vld_s[k];
		end
	end

	always_ff @(posedge clk) begin
		dv_s[0] <= d0;
		for (int k = 0; k < DIV_STAGES; k++) dv_s[k+1] <= div_step(dv_s[k]);
	end

	assign fin = dv_s[DIV_STAGES];

	always_comb begin
		out_res.pair_kind      = fin.kind;
		out_res.first_channel  = '0;
		out_res.first_gain     = '0;
		out_res.second_channel = '0;
		out_res.second_gain    = '0;
		unique case (fin.kind)
			KIND_ONE: begin
				out_res.first_channel = fin.fch;
				out_res.first_gain    = GAIN_W'(UNITY);
			end
			KIND_PAIR: begin
				out_res.first_channel  = fin.fch;
				out_res.first_gain     = GAIN_W'(UNITY) - fin.quo;
				out_res.second_channel = fin.sch;
				out_res.second_gain    = fin.quo;
			end
			default: begin
				out_res.pair_kind = KIND_NONE;
			end
		endcase
	end

	assign out_valid = vld_s[DIV_STAGES];
endmodule

FILE: rtl/core/ring_pan_gain_calculator_top.sv
// ----------------------------------------------------------------------------
// ring_pan_gain_calculator_top
// pairwise linear panning of one angle onto the configured speaker ring
// ----------------------------------------------------------------------------
// channel   direction  handshake            payload
// input     in         push / full          pan_angle
// result    out        pop / empty          first_channel first_gain second_channel
//                                           second_gain pair_kind
// config    in         cfg_valid/cfg_ready  cfg_index cfg_data
//
// one item per cycle while full is low; from push to result on the queue head an item
// passes five front stages, the middle queue and nine divider stages.
// the result queue holds 32 items; full rises when 32 items are in flight or
// waiting or the middle queue is full, so results are never dropped while pop is low.
// reset clears both registers, all valid bits and both queues.
// ----------------------------------------------------------------------------
module ring_pan_gain_calculator_top #(
	parameter int MAX_CHANNELS = rpg_pkg::MAX_CHANNELS_DEF,
	parameter int RING_MAX     = rpg_pkg::RING_MAX_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	output logic               full,
	input  logic signed [15:0] pan_angle,
	output logic               empty,
	input  logic               pop,
	output logic [3:0]         first_channel,
	output logic [15:0]        first_gain,
	output logic [3:0]         second_channel,
	output logic [15:0]        second_gain,
	output logic [1:0]         pair_kind,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic               cfg_index,
	input  logic [63:0]        cfg_data
);
	import rpg_pkg::*;

	localparam int CW = $clog2(OUT_DEPTH + 1);

	logic [4:0]  channel_count_q;
	logic [63:0] speaker_layout_q;
	logic [CW-1:0] cnt_q;
	logic        in_acc, out_acc;

	logic        f_valid;
	front_item_t f_item;
	logic [$bits(front_item_t)-1:0] mid_rdata;
	logic        mid_full, mid_empty;
	logic        mid_pop;
	logic        b_valid;
	result_t     b_res;
	logic [$bits(result_t)-1:0] out_rdata;
	logic        out_full;
	result_t     head;

	assign cfg_ready = 1'b1;
	assign full      = (cnt_q == CW'(OUT_DEPTH)) || mid_full;
	assign in_acc    = push && !full;
	assign out_acc   = pop && !empty;
	assign mid_pop   = !mid_empty && !out_full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			channel_count_q  <= '0;
			speaker_layout_q <= '0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_COUNT:  channel_count_q  <= cfg_data[4:0];
				CFG_LAYOUT: speaker_layout_q <= cfg_data;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (in_acc && !out_acc) begin
			cnt_q <= cnt_q + 1'b1;
		end else if (out_acc && !in_acc) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	rpg_front #(
		.MAX_CHANNELS(MAX_CHANNELS),
		.RING_MAX(RING_MAX)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.channel_count(channel_count_q),
		.speaker_layout(speaker_layout_q),
		.in_valid(in_acc),
		.pan_angle(pan_angle),
		.out_valid(f_valid),
		.out_item(f_item)
	);

	rpg_fifo #(
		.WIDTH($bits(front_item_t)),
		.DEPTH(MID_DEPTH)
	) u_mid (
		.clk(clk),
		.arst_n(arst_n),
		.push(f_valid),
		.wdata(f_item),
		.full(mid_full),
		.pop(mid_pop),
		.rdata(mid_rdata),
		.empty(mid_empty)
	);

	rpg_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(mid_pop),
		.in_item(front_item_t'(mid_rdata)),
		.out_valid(b_valid),
		.out_res(b_res)
	);

	rpg_fifo #(
		.WIDTH($bits(result_t)),
		.DEPTH(OUT_DEPTH)
	) u_out (
		.clk(clk),
		.arst_n(arst_n),
		.push(b_valid),
		.wdata(b_res),
		.full(out_full),
		.pop(pop),
		.rdata(out_rdata),
		.empty(empty)
	);

	assign head           = result_t'(out_rdata);
	assign first_channel  = head.first_channel;
	assign first_gain     = head.first_gain;
	assign second_channel = head.second_channel;
	assign second_gain    = head.second_gain;
	assign pair_kind      = head.pair_kind;
endmodule

FILE: rtl/core/rpg_checker.sv
// ----------------------------------------------------------------------------
// rpg_checker
// port-level checks on the result queue of the gain calculator
// ----------------------------------------------------------------------------
`include "ring_pan_gain_calculator_top_assert.svh"

module rpg_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        pop,
	input logic        empty,
	input logic [15:0] first_gain,
	input logic [3:0]  second_channel,
	input logic [15:0] second_gain,
	input logic [1:0]  pair_kind
);
	import rpg_pkg::*;

	`RPG_ASSERT_NOW(a_pair_sum, !empty && pair_kind == KIND_PAIR, ({1'b0, first_gain} + {1'b0, second_gain}) == 17'(UNITY), "pair gains do not sum to unity")
	`RPG_ASSERT_NOW(a_single_unity, !empty && pair_kind == KIND_ONE, first_gain == 16'(UNITY), "single channel not at unity")
	`RPG_ASSERT_NOW(a_second_zero, !empty && pair_kind != KIND_PAIR, second_gain == '0 && second_channel == '0, "second channel set without a pair")
	`RPG_ASSERT_NEXT(a_hold_head, !empty && !pop, !empty, "waiting item lost")
endmodule

bind ring_pan_gain_calculator_top rpg_checker u_rpg_checker (.*);

FILE: bench/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// drives pan angles through the ring pan gain calculator under a range of
// speaker layouts and checks every result against an in-bench gain predictor
// ----------------------------------------------------------------------------

class pan_gain_scoreboard;
	rpg_pkg::result_t gains_due[$];
	logic [4:0]  count_reg;
	logic [63:0] layout_reg;
	int errors;

	function void note_angle(logic signed [15:0] ang);
		gains_due.push_back(predict_result(ang));
	endfunction

	function rpg_pkg::result_t predict_result(logic signed [15:0] ang);
		rpg_pkg::result_t r;
		int az[16];
		int ch[16];
		int n, pts, j, t, last, a, b, span, into, g2, v;
		bit seven;
		logic [3:0] code;
		r = '0;
		r.pair_kind = rpg_pkg::KIND_NONE;
		n = (count_reg > 16) ? 16 : count_reg;
		seven = 0;
		pts = 0;
		for (int c = 0; c < n; c++) begin
			code = layout_reg[4*c +: 4];
			if (code >= 5 && code <= 10) seven = 1;
		end
		for (int c = 0; c < n; c++) begin
			code = layout_reg[4*c +: 4];
			if (code <= 8) begin
				case (code)
					0: v = 5280;
					1: v = 0;
					2: v = 480;
					3: v = seven ? 4320 : 4000;
					4: v = seven ? 1440 : 1760;
					5: v = 3600;
					6: v = 2160;
					7: v = 4800;
					default: v = 960;
				endcase
				j = pts;
				while (j > 0 && az[j-1] > v) begin
					az[j] = az[j-1];
					ch[j] = ch[j-1];
					j--;
				end
				az[j] = v;
				ch[j] = c;
				pts++;
			end
		end
		if (pts == 0) return r;
		t = int'(ang) % 5760;
		if (t < 0) t += 5760;
		for (int i = 0; i < pts; i++)
			if (az[i] == t) begin
				r.first_channel = 4'(ch[i]);
				r.first_gain = 16'h8000;
				r.pair_kind = rpg_pkg::KIND_ONE;
				return r;
			end
		last = pts - 1;
		for (int i = 0; i < pts; i++)
			if (az[i] < t) last = i;
		a = last;
		while (a > 0 && az[a-1] == az[last]) a--;
		b = (last + 1) % pts;
		r.first_channel = 4'(ch[a]);
		if (pts == 1 || az[b] == az[a]) begin
			r.first_gain = 16'h8000;
			r.pair_kind = rpg_pkg::KIND_ONE;
			return r;
		end
		span = (az[b] - az[a] + 11520) % 5760;
		if (span == 0) span = 5760;
		into = (t - az[a] + 11520) % 5760;
		if (into == 0) into = 5760;
		if (into > span) into = span;
		g2 = (into * 32768 + span / 2) / span;
		r.first_gain = 16'(32768 - g2);
		r.second_channel = 4'(ch[b]);
		r.second_gain = 16'(g2);
		r.pair_kind = rpg_pkg::KIND_PAIR;
		return r;
	endfunction

	function void check_gains(rpg_pkg::result_t got);
		rpg_pkg::result_t e;
		if (gains_due.size() == 0) begin
			$display("%0t: unexpected item, expected none, actual %p", $time, got);
			errors++;
			return;
		end
		e = gains_due.pop_front();
		if (got.first_channel !== e.first_channel) begin
			$display("%0t: first_channel expected %0d actual %0d", $time,
				e.first_channel, got.first_channel);
			errors++;
		end
		if (got.first_gain !== e.first_gain) begin
			$display("%0t: first_gain expected %0d actual %0d", $time,
				e.first_gain, got.first_gain);
			errors++;
		end
		if (got.second_channel !== e.second_channel) begin
			$display("%0t: second_channel expected %0d actual %0d", $time,
				e.second_channel, got.second_channel);
			errors++;
		end
		if (got.second_gain !== e.second_gain) begin
			$display("%0t: second_gain expected %0d actual %0d", $time,
				e.second_gain, got.second_gain);
			errors++;
		end
		if (got.pair_kind !== e.pair_kind) begin
			$display("%0t: pair_kind expected %0d actual %0d", $time,
				e.pair_kind, got.pair_kind);
			errors++;
		end
	endfunction
endclass

module tb;
	import rpg_pkg::*;

	logic clk = 0;
	logic arst_n = 0;
	logic push = 0;
	logic full;
	logic signed [15:0] pan_angle = '0;
	logic empty;
	logic pop = 0;
	logic [3:0] first_channel;
	logic [15:0] first_gain;
	logic [3:0] second_channel;
	logic [15:0] second_gain;
	logic [1:0] pair_kind;
	logic cfg_valid = 0;
	logic cfg_ready;
	logic cfg_index = CFG_COUNT;
	logic [63:0] cfg_data = '0;

	pan_gain_scoreboard sb = new();
	bit calm = 0;
	int hold_off = 0;

	ring_pan_gain_calculator_top dut (.*);

	always begin
		#1 clk = 1;
		#1 clk = 0;
	end

	task automatic write_reg(logic idx, logic [63:0] val);
		@(negedge clk);
		cfg_valid <= 1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		if (idx == CFG_COUNT) sb.count_reg = val[4:0];
		else sb.layout_reg = val;
		@(negedge clk);
		cfg_valid <= 0;
	endtask

	// called at a falling edge, returns at a falling edge with push still high
	task automatic send_angle(logic signed [15:0] ang);
		while (!calm && $urandom_range(99) < 7) begin
			push <= 0;
			@(negedge clk);
		end
		push <= 1;
		pan_angle <= ang;
		do @(posedge clk); while (full);
		sb.note_angle(ang);
		@(negedge clk);
	endtask

	task automatic drain;
		while (sb.gains_due.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	function automatic logic signed [15:0] rand_angle();
		case ($urandom_range(3))
			0: return 16'($urandom);
			1: return 16'($urandom_range(5759));
			2: return 16'(-$urandom_range(5760));
			default: return 16'($urandom_range(11) * 480);
		endcase
	endfunction

	always @(negedge clk) begin
		if (hold_off > 0) begin
			hold_off--;
			pop <= 0;
		end else
			pop <= calm || ($urandom_range(99) >= 7);
	end

	always @(posedge clk)
		if (arst_n && pop && !empty)
			sb.check_gains('{first_channel, first_gain, second_channel,
				second_gain, kind_t'(pair_kind)});

	initial begin
		logic signed [15:0] edge_angles[$];
		logic [63:0] layouts[$];
		logic [4:0] counts[$];
		logic [63:0] lay;
		edge_angles = '{16'sh7fff, -16'sh8000, 0, 5760, -5760, 5280, -480, 480, 1760,
			4000, 4320, 1440, 3600, 2160, 4800, 960, 1, -1, 240, 5759, 16'sh5555,
			-16'sh5556};
		layouts = '{64'h0, 64'h0000_0000_0043_B210, 64'h0000_0000_8765_4321,
			64'h1111_1111_1111_1111, 64'hFFFF_FFFF_FFFF_FFFF, 64'h0000_0000_0000_0001,
			64'h0000_0000_0000_00B9, 64'h8765_4321_0876_5432,
			64'h0000_0000_00B4_3210};
		counts = '{0, 6, 8, 16, 16, 1, 2, 31, 6};
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1;
		for (int p = 0; p < layouts.size(); p++) begin
			write_reg(CFG_LAYOUT, layouts[p]);
			write_reg(CFG_COUNT, 64'(counts[p]));
			if (p == 1) foreach (edge_angles[k]) send_angle(edge_angles[k]);
			for (int k = 0; k < 60; k++) send_angle(rand_angle());
			push <= 0;
			drain();
		end
		for (int p = 0; p < 14; p++) begin
			lay = {$urandom, $urandom};
			if (p % 2) for (int c = 0; c < 16; c++) lay[4*c +: 4] = 4'($urandom_range(8));
			write_reg(CFG_LAYOUT, lay);
			write_reg(CFG_COUNT, 64'($urandom_range(31)));
			calm = (p == 3);
			if (p == 5) hold_off = 300;
			for (int k = 0; k < 55; k++) send_angle(rand_angle());
			push <= 0;
			drain();
		end
		if (sb.errors == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

	initial begin
		#2000000;
		$display("Mismatches found");
		$finish;
	end
endmodule
